/* design/cbd_pkg.sv */
package cbd_pkg;

   // Source position counters (source sizes stay below 256).
   localparam int POS_W = 8;
   // Accumulator columns (one per output column of the small image).
   localparam int NUM_COLS = 32;
   localparam int COL_W = 5;

   localparam int RED_SUM_W = 9;
   localparam int GREEN_SUM_W = 10;
   localparam int BLUE_SUM_W = 9;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROP_TOP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CROP_LEFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_MODE = 2'd2;

   localparam logic [4:0] CROP_TOP_RESET = 5'd8;
   localparam logic [5:0] CROP_LEFT_RESET = 6'd22;
   localparam logic AVERAGE_MODE_RESET = 1'b1;

   typedef struct packed {
      logic [RED_SUM_W-1:0] red;
      logic [GREEN_SUM_W-1:0] green;
      logic [BLUE_SUM_W-1:0] blue;
   } sum_type;

   // Where the current source pixel falls in the crop window.
   typedef struct packed {
      logic in_win;
      logic first;
      logic last;
      logic frame_last;
      logic [COL_W-1:0] br;
      logic [COL_W-1:0] bc;
   } win_info_type;

endpackage

/* design/crop_box_downscale_rgb565_unit.sv */
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | req_pixel, req_frame_start
// rsp     | out       | rsp_valid/stall    | rsp_out_pixel, rsp_out_row, rsp_out_col,
//         |           |                    | rsp_frame_done
// csr     | in        | csr_write          | csr_index, csr_data
//
// One item per cycle sustained while the result side is not stalled; an item's
// result passes through the input register, then the result register.
// The rate is set by the read-modify-write of one column accumulator.
// Synchronous reset clears counters, accumulators and valids, and loads the config registers with their reset values.
// A stalled result holds the result register; the input register drains into it
// as soon as it frees, so one extra item can wait at the input.
module crop_box_downscale_rgb565_unit
   import cbd_pkg::*;
#(
   parameter int SRC_WIDTH = 176,
   parameter int SRC_HEIGHT = 144,
   parameter int OUT_SIZE = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [15:0] req_pixel,
   input  logic req_frame_start,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_out_pixel,
   output logic [4:0] rsp_out_row,
   output logic [4:0] rsp_out_col,
   output logic rsp_frame_done,
   input  logic csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [4:0] crop_top_ff;
   logic [5:0] crop_left_ff;
   logic average_mode_ff;

   // Input register.
   logic in_valid_ff, in_valid_in;
   logic [15:0] in_pixel_ff;
   logic in_frame_start_ff;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_pixel_ff;
   logic [4:0] rsp_row_ff, rsp_col_ff;
   logic rsp_done_ff;

   logic out_free, advance, req_take;
   win_info_type win;
   logic [15:0] result_pixel;

   // Process the held item whenever the result register can take a result.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_top_ff <= CROP_TOP_RESET;
         crop_left_ff <= CROP_LEFT_RESET;
         average_mode_ff <= AVERAGE_MODE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CROP_TOP: crop_top_ff <= csr_data[4:0];
            CSR_CROP_LEFT: crop_left_ff <= csr_data[5:0];
            CSR_AVERAGE_MODE: average_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Hold an item until it is processed; load a new one in the same cycle.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_pixel_ff <= req_pixel;
         in_frame_start_ff <= req_frame_start;
      end
   end

   cbd_window #(
      .SRC_WIDTH(SRC_WIDTH),
      .SRC_HEIGHT(SRC_HEIGHT),
      .OUT_SIZE(OUT_SIZE)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .frame_start(in_frame_start_ff),
      .crop_top(crop_top_ff),
      .crop_left(crop_left_ff),
      .win(win)
   );

   cbd_accum u_accum (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .win(win),
      .pixel(in_pixel_ff),
      .average_mode(average_mode_ff),
      .out_pixel(result_pixel)
   );

   // A result leaves at the bottom-right pixel of each block in the window.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = win.in_win && win.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && win.in_win && win.last) begin
         rsp_pixel_ff <= result_pixel;
         rsp_row_ff <= win.br;
         rsp_col_ff <= win.bc;
         rsp_done_ff <= win.frame_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

/* design/cbd_window.sv */
module cbd_window
   import cbd_pkg::*;
#(
   parameter int SRC_WIDTH = 176,
   parameter int SRC_HEIGHT = 144,
   parameter int OUT_SIZE = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic frame_start,
   input  logic [4:0] crop_top,
   input  logic [5:0] crop_left,
   output win_info_type win
);

   localparam int WIN_SIZE = 4 * OUT_SIZE;

   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] cur_row, cur_col;
   logic [POS_W-1:0] diff_row, diff_col;
   logic [POS_W:0] row_inc, col_inc;
   logic in_row, in_col;

   assign cur_row = frame_start ? '0 : row_ff;
   assign cur_col = frame_start ? '0 : col_ff;

   assign diff_row = cur_row - {{(POS_W-5){1'b0}}, crop_top};
   assign diff_col = cur_col - {{(POS_W-6){1'b0}}, crop_left};

   assign in_row = (cur_row >= {{(POS_W-5){1'b0}}, crop_top})
      && ({1'b0, diff_row} < (POS_W+1)'(WIN_SIZE));
   assign in_col = (cur_col >= {{(POS_W-6){1'b0}}, crop_left})
      && ({1'b0, diff_col} < (POS_W+1)'(WIN_SIZE));

   always_comb begin
      win.in_win = in_row && in_col;
      win.br = diff_row[COL_W+1:2];
      win.bc = diff_col[COL_W+1:2];
      win.first = (diff_row[1:0] == 2'd0) && (diff_col[1:0] == 2'd0);
      win.last = (diff_row[1:0] == 2'd3) && (diff_col[1:0] == 2'd3);
      win.frame_last = (win.br == COL_W'(OUT_SIZE - 1))
         && (win.bc == COL_W'(OUT_SIZE - 1));
   end

   // Advance in raster order, wrap at the source edges.
   always_comb begin
      col_inc = {1'b0, cur_col} + (POS_W+1)'(1);
      row_inc = {1'b0, cur_row} + (POS_W+1)'(1);
      row_in = cur_row;
      col_in = col_inc[POS_W-1:0];
      if (col_inc >= (POS_W+1)'(SRC_WIDTH)) begin
         col_in = '0;
         row_in = (row_inc >= (POS_W+1)'(SRC_HEIGHT)) ? '0 : row_inc[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* design/cbd_accum.sv */
module cbd_accum
   import cbd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  win_info_type win,
   input  logic [15:0] pixel,
   input  logic average_mode,
   output logic [15:0] out_pixel
);

   sum_type sums_ff [NUM_COLS];
   sum_type cur_sum, load_sum, add_sum, sum_in;

   assign cur_sum = sums_ff[win.bc];

   always_comb begin
      load_sum.red = {4'd0, pixel[15:11]};
      load_sum.green = {4'd0, pixel[10:5]};
      load_sum.blue = {4'd0, pixel[4:0]};
      add_sum.red = cur_sum.red + load_sum.red;
      add_sum.green = cur_sum.green + load_sum.green;
      add_sum.blue = cur_sum.blue + load_sum.blue;
      if (win.first) begin
         sum_in = load_sum;
      end else if (average_mode) begin
         sum_in = add_sum;
      end else begin
         sum_in = cur_sum;
      end
   end

   // Divide by 16 in average mode; otherwise keep the low field bits.
   always_comb begin
      if (average_mode) begin
         out_pixel = {sum_in.red[8:4], sum_in.green[9:4], sum_in.blue[8:4]};
      end else begin
         out_pixel = {sum_in.red[4:0], sum_in.green[5:0], sum_in.blue[4:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COLS; i++) begin
            sums_ff[i] <= '0;
         end
      end else if (advance && win.in_win) begin
         sums_ff[win.bc] <= sum_in;
      end
   end

endmodule
